FILE: hw/rtl/hbs_pkg.sv
// hbs_pkg: shared types and constants for the height map bilinear sampler.
// Used by heightmap_bilinear_sampler_core and hbs_checker; no dependencies.
`default_nettype none

package hbs_pkg;

    // Default build parameters
    localparam int MAP_DIM_DEF   = 256;
    localparam int FRAC_BITS_DEF = 8;

    // Field widths fixed by the interface
    localparam int COORD_W  = 16;
    localparam int HEIGHT_W = 8;
    localparam int OUT_W    = 24;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Largest blended height: 255 in 8.16 fixed point
    localparam logic [OUT_W-1:0] HEIGHT_OUT_MAX = 24'hFF0000;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_COUNT_RESET = 9'd256;

    // Request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Neighbor read sequence: index of the last of the four reads
    localparam logic [1:0] PIX_LAST = 2'd3;

    // Sample sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } state_t;

    // Input transaction
    typedef struct packed {
        logic                req_type;
        logic [COORD_W-1:0]  coord_x;
        logic [COORD_W-1:0]  coord_y;
        logic [HEIGHT_W-1:0] height_in;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic [OUT_W-1:0] height_out;
        logic             out_of_range;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/heightmap_bilinear_sampler_core.sv
// heightmap_bilinear_sampler_core: height store plus bilinear sampler.
// Depends on hbs_pkg for transaction types, register indexes and states.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  request  | start, busy (take: start & !busy) | req (hbs_pkg::req_t)
//  result   | done (one-cycle strobe)   | result (hbs_pkg::result_t)
//  config   | cfg_wr_en                 | cfg_index, cfg_data
//
// A write transaction's result strobes in the next cycle.
// In a sample transaction the four neighbor heights come out of the height
// store one per cycle, followed by a multiply stage and an accumulate stage,
// after which the result strobes.
// Reset clears the sequencer and sets both map counts to 256; the height store
// is not cleared and holds garbage until written.
// The result side has no stall: done is high for exactly one cycle.
`default_nettype none

module heightmap_bilinear_sampler_core #(
    parameter int MAP_DIM   = hbs_pkg::MAP_DIM_DEF,
    parameter int FRAC_BITS = hbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request
    input  wire logic                             start,
    output logic                                  busy,
    input  wire hbs_pkg::req_t                    req,
    // result
    output logic                                  done,
    output hbs_pkg::result_t                      result,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [hbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hbs_pkg::CFG_W-1:0]        cfg_data
);

    // Derived widths
    localparam int CW     = $clog2(MAP_DIM);            // column / row index
    localparam int AW     = 2 * CW;                     // store address
    localparam int DEPTH  = 1 << AW;
    localparam int DIM_W  = $clog2(MAP_DIM + 1);
    localparam int CMP_W0 = (hbs_pkg::COORD_W > hbs_pkg::CFG_W) ?
                            hbs_pkg::COORD_W : hbs_pkg::CFG_W;
    localparam int CMP_W  = (CMP_W0 > DIM_W) ? CMP_W0 : DIM_W;
    localparam int WX_W   = FRAC_BITS + 1;              // axis weight
    localparam int WT_W   = 2 * WX_W;                   // pixel weight
    localparam int PROD_W = hbs_pkg::HEIGHT_W + WT_W;
    localparam int ACC_W  = hbs_pkg::HEIGHT_W + 2 * FRAC_BITS;
    localparam int SHR    = (2 * FRAC_BITS >= 16) ? (2 * FRAC_BITS - 16) : 0;
    localparam int SHL    = (2 * FRAC_BITS < 16) ? (16 - 2 * FRAC_BITS) : 0;
    localparam logic [WX_W-1:0]  W_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CMP_W-1:0] DIM_CMP = CMP_W'(MAP_DIM);

    // Height store
    logic [hbs_pkg::HEIGHT_W-1:0] mem [DEPTH];

    // Configuration registers
    logic [hbs_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [hbs_pkg::CFG_W-1:0] rows_cfg_reg;

    // Sequencer
    hbs_pkg::state_t state_reg, state_next;
    logic [1:0]      k_reg;

    // Sample context captured at acceptance
    logic [CW-1:0]   x0_reg, x1_reg, y0_reg, y1_reg;
    logic [WX_W-1:0] wx0_reg, wx1_reg, wy0_reg, wy1_reg;
    logic            oor_reg;

    // Read / multiply / accumulate pipeline
    logic                         va_reg, la_reg, vb_reg, lb_reg;
    logic [WT_W-1:0]              wt_reg;
    logic [hbs_pkg::HEIGHT_W-1:0] rd_data_reg;
    logic [ACC_W-1:0]             prod_reg;
    logic [ACC_W-1:0]             acc_reg;

    // Result register
    hbs_pkg::result_t res_reg;
    logic             done_reg;

    // Combinational signals
    logic                   accept, is_sample, issue;
    logic [CMP_W-1:0]       cols_eff, rows_eff;
    logic [CMP_W-1:0]       ix_ext, iy_ext, ix_cl, iy_cl, x1_ext, y1_ext;
    logic                   oor_x, oor_y, oor;
    logic [FRAC_BITS-1:0]   fx, fy;
    logic                   mem_we;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [WX_W-1:0]        wx_sel, wy_sel;
    logic [WT_W-1:0]        wt_full;
    logic [PROD_W-1:0]      prod_full;
    logic [ACC_W-1:0]       sum_final;
    logic [hbs_pkg::OUT_W-1:0] height_scaled;

    assign busy   = (state_reg != hbs_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign is_sample = (req.req_type == hbs_pkg::REQ_SAMPLE);
    assign issue  = (state_reg == hbs_pkg::ST_READ);

    // Active map size, out-of-range counts saturated to 1..MAP_DIM
    always_comb
    begin
        if (cols_cfg_reg == '0)
            cols_eff = CMP_W'(1);
        else if (CMP_W'(cols_cfg_reg) > DIM_CMP)
            cols_eff = DIM_CMP;
        else
            cols_eff = CMP_W'(cols_cfg_reg);

        if (rows_cfg_reg == '0)
            rows_eff = CMP_W'(1);
        else if (CMP_W'(rows_cfg_reg) > DIM_CMP)
            rows_eff = DIM_CMP;
        else
            rows_eff = CMP_W'(rows_cfg_reg);
    end

    // Coordinate split, range check and neighbor clamping
    always_comb
    begin
        ix_ext = CMP_W'(req.coord_x >> FRAC_BITS);
        iy_ext = CMP_W'(req.coord_y >> FRAC_BITS);
        fx     = req.coord_x[FRAC_BITS-1:0];
        fy     = req.coord_y[FRAC_BITS-1:0];
        oor_x  = (ix_ext >= cols_eff);
        oor_y  = (iy_ext >= rows_eff);
        oor    = oor_x || oor_y;
        ix_cl  = oor_x ? (cols_eff - CMP_W'(1)) : ix_ext;
        iy_cl  = oor_y ? (rows_eff - CMP_W'(1)) : iy_ext;
        x1_ext = ((ix_cl + CMP_W'(1)) < cols_eff) ? (ix_cl + CMP_W'(1))
                                                   : (cols_eff - CMP_W'(1));
        y1_ext = ((iy_cl + CMP_W'(1)) < rows_eff) ? (iy_cl + CMP_W'(1))
                                                   : (rows_eff - CMP_W'(1));
    end

    // Store write port: write transactions inside the active map
    assign mem_we  = accept && !is_sample && !oor;
    assign wr_addr = {iy_ext[CW-1:0], ix_ext[CW-1:0]};

    // Read address and weight for neighbor k: bit 0 picks column, bit 1 row
    always_comb
    begin
        rd_addr = {(k_reg[1] ? y1_reg : y0_reg), (k_reg[0] ? x1_reg : x0_reg)};
        wx_sel  = k_reg[0] ? wx1_reg : wx0_reg;
        wy_sel  = k_reg[1] ? wy1_reg : wy0_reg;
        wt_full = WT_W'(wx_sel) * WT_W'(wy_sel);
    end

    // Height store, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= req.height_in;
        if (issue)
            rd_data_reg <= mem[rd_addr];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= hbs_pkg::CFG_COUNT_RESET;
            rows_cfg_reg <= hbs_pkg::CFG_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hbs_pkg::CFG_MAP_COLS: cols_cfg_reg <= cfg_data;
                hbs_pkg::CFG_MAP_ROWS: rows_cfg_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hbs_pkg::ST_IDLE:
            begin
                if (accept && is_sample)
                    state_next = hbs_pkg::ST_READ;
            end
            hbs_pkg::ST_READ:
            begin
                if (k_reg == hbs_pkg::PIX_LAST)
                    state_next = hbs_pkg::ST_DRAIN;
            end
            hbs_pkg::ST_DRAIN:
            begin
                if (lb_reg)
                    state_next = hbs_pkg::ST_IDLE;
            end
            default: state_next = hbs_pkg::ST_IDLE;
        endcase
    end

    // Control registers: state, read counter, pipeline valids, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbs_pkg::ST_IDLE;
            k_reg     <= '0;
            va_reg    <= 1'b0;
            la_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            lb_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                k_reg <= '0;
            else if (issue)
                k_reg <= k_reg + 2'd1;
            va_reg   <= issue;
            la_reg   <= issue && (k_reg == hbs_pkg::PIX_LAST);
            vb_reg   <= va_reg;
            lb_reg   <= la_reg;
            done_reg <= (accept && !is_sample) || lb_reg;
        end
    end

    // Sample context capture
    always_ff @(posedge clk)
    begin
        if (accept && is_sample)
        begin
            x0_reg  <= ix_cl[CW-1:0];
            x1_reg  <= x1_ext[CW-1:0];
            y0_reg  <= iy_cl[CW-1:0];
            y1_reg  <= y1_ext[CW-1:0];
            wx0_reg <= W_ONE - WX_W'(fx);
            wx1_reg <= WX_W'(fx);
            wy0_reg <= W_ONE - WX_W'(fy);
            wy1_reg <= WX_W'(fy);
            oor_reg <= oor;
        end
    end

    // Multiply and accumulate
    assign prod_full = PROD_W'(rd_data_reg) * PROD_W'(wt_reg);
    assign sum_final = acc_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        if (issue)
            wt_reg <= wt_full;
        if (va_reg)
            prod_reg <= prod_full[ACC_W-1:0];
        if (accept)
            acc_reg <= '0;
        else if (vb_reg)
            acc_reg <= sum_final;
    end

    // Scale the blend to 8.16
    assign height_scaled = hbs_pkg::OUT_W'(sum_final >> SHR) << SHL;

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept && !is_sample)
        begin
            res_reg.height_out   <= '0;
            res_reg.out_of_range <= oor;
        end
        else if (lb_reg)
        begin
            res_reg.height_out   <= height_scaled;
            res_reg.out_of_range <= oor_reg;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hbs_checker.sv
// hbs_checker: port-level timing checks for heightmap_bilinear_sampler_core.
// Depends on hbs_pkg; bound to the core at the end of this file.
`default_nettype none

module hbs_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire hbs_pkg::req_t    req,
    input wire logic             done,
    input wire hbs_pkg::result_t result
);

    logic take_write, take_sample;

    assign take_write  = start && !busy && (req.req_type == hbs_pkg::REQ_WRITE);
    assign take_sample = start && !busy && (req.req_type == hbs_pkg::REQ_SAMPLE);

    // A write transaction answers in the next cycle with a zero height
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_write |=> done && (result.height_out == '0))
        else $error("write transaction result missing or nonzero");

    // A sample transaction holds the request side off and shows no result yet
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take_sample |=> busy && !done)
        else $error("sample transaction did not hold busy");

    // A sample transaction's result strobes with busy already gone
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take_sample |-> ##7 (done && !busy))
        else $error("sample transaction result not on time");

    // A blended height never exceeds the largest pixel value
    a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.height_out <= hbs_pkg::HEIGHT_OUT_MAX))
        else $error("blended height out of range");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);

`default_nettype wire
